// ===== sv/edc_pkg.sv =====
// Elevator dispatch controller: shared types and fixed field widths.
// Depends on nothing; compile first.
package edc_pkg;

  localparam int FLOOR_W = 5;   // floor fields on the ports
  localparam int FUNC_W  = 2;
  localparam int CMD_W   = 3;
  localparam int DIR_W   = 2;
  localparam int STATE_W = 2;

  typedef enum logic [FUNC_W-1:0] {
    FN_REQUEST = 2'd0,
    FN_MOVED   = 2'd1,
    FN_READY   = 2'd2
  } func_t;

  typedef enum logic [CMD_W-1:0] {
    CMD_NONE    = 3'd0,
    CMD_OPEN    = 3'd1,
    CMD_GO_ON   = 3'd2,
    CMD_STOP    = 3'd3,
    CMD_PREPARE = 3'd4
  } cmd_t;

  localparam logic signed [DIR_W-1:0] DIR_DOWN = -2'sd1;
  localparam logic signed [DIR_W-1:0] DIR_STAY = 2'sd0;
  localparam logic signed [DIR_W-1:0] DIR_UP   = 2'sd1;

  // Reported controller state codes
  localparam logic [STATE_W-1:0] CODE_FREE   = 2'd0;
  localparam logic [STATE_W-1:0] CODE_CHOOSE = 2'd1;
  localparam logic [STATE_W-1:0] CODE_MOVE   = 2'd2;
  localparam logic [STATE_W-1:0] CODE_STOP   = 2'd3;

endpackage

// ===== sv/edc_in_if.sv =====
// Input channel of the elevator dispatch controller: valid/ready plus request payload.
// Depends on edc_pkg.
interface edc_in_if;
  import edc_pkg::*;

  logic               valid;
  logic               ready;
  logic [FUNC_W-1:0]  func;
  logic [FLOOR_W-1:0] floor;

  modport source (output valid, output func, output floor, input ready);
  modport sink   (input valid, input func, input floor, output ready);
endinterface

// ===== sv/edc_out_if.sv =====
// Result channel of the elevator dispatch controller: valid/ready plus command payload.
// Depends on edc_pkg.
interface edc_out_if;
  import edc_pkg::*;

  logic                     valid;
  logic                     ready;
  logic [CMD_W-1:0]         command;
  logic signed [DIR_W-1:0]  move_dir;
  logic [FLOOR_W-1:0]       floor_now;
  logic [STATE_W-1:0]       ctrl_state;

  modport source (output valid, output command, output move_dir, output floor_now,
                  output ctrl_state, input ready);
  modport sink   (input valid, input command, input move_dir, input floor_now,
                  input ctrl_state, output ready);
endinterface

// ===== sv/elevator_dispatch_controller_top.sv =====
// Elevator dispatch controller, nearest-request scheme: top level.
// Depends on edc_pkg, edc_in_if and edc_out_if.
//
//  channel   dir  handshake        payload
//  in_chan   in   valid/ready      func[1:0], floor[4:0]
//  out_chan  out  valid/ready      command[2:0], move_dir[1:0] signed,
//                                  floor_now[4:0], ctrl_state[1:0]
//  cfg_*     in   cfg_we (no wait) cfg_wdata[4:0] = start floor
//
// Flow: a request, move or ready transaction that needs no target search
// is written to the result register when it is accepted. One that needs a
// search walks the request bits one floor a cycle in the comparator, then
// the FIN state commits the target. Only one transaction is in flight; a new
// one is taken when the sequencer is idle and the result register is free or
// being emptied in the same cycle. Reset is synchronous, active low, and
// clears all control state; the start floor returns to 1.
module elevator_dispatch_controller_top #(
  parameter int FLOORS = 16           // 2..64
) (
  input  logic                      clk,
  input  logic                      rst_n,
  edc_in_if.sink                    in_chan,
  edc_out_if.source                 out_chan,
  input  logic                      cfg_we,
  input  logic [edc_pkg::FLOOR_W-1:0] cfg_wdata
);
  import edc_pkg::*;

  // Bit index into the request vector, and a counter wide enough for FLOORS+1
  localparam int IDX_W = (FLOORS > 2) ? $clog2(FLOORS) : 1;
  localparam int CW    = $clog2(FLOORS + 2);
  // Floor fields are 5 bits wide, so the highest reachable floor is capped
  localparam logic [FLOOR_W-1:0] FLOOR_MAX = FLOOR_W'((FLOORS > 31) ? 31 : FLOORS);
  localparam logic [CW-1:0]      SCAN_LAST = CW'(FLOORS);
  localparam logic [CW-1:0]      DIST_INIT = CW'(FLOORS + 1);

  // Sequencer around the shared distance comparator
  typedef enum logic [2:0] {
    SQ_IDLE = 3'b001,
    SQ_SCAN = 3'b010,
    SQ_FIN  = 3'b100
  } seq_t;

  // Controller phase (the architectural state)
  typedef enum logic [3:0] {
    PH_FREE   = 4'b0001,
    PH_CHOOSE = 4'b0010,
    PH_MOVE   = 4'b0100,
    PH_STOP   = 4'b1000
  } phase_t;

  function automatic logic [FLOOR_W-1:0] clamp_floor(input logic [FLOOR_W-1:0] f);
    logic [FLOOR_W-1:0] r;
    r = f;
    if (f == '0) r = FLOOR_W'(1);
    else if (f > FLOOR_MAX) r = FLOOR_MAX;
    return r;
  endfunction

  function automatic logic [STATE_W-1:0] phase_code(input phase_t p);
    logic [STATE_W-1:0] c;
    case (p)
      PH_FREE:   c = CODE_FREE;
      PH_CHOOSE: c = CODE_CHOOSE;
      PH_MOVE:   c = CODE_MOVE;
      PH_STOP:   c = CODE_STOP;
      default:   c = CODE_FREE;
    endcase
    return c;
  endfunction

  // Architectural state
  logic [FLOOR_W-1:0]       start_r, start_nxt;
  logic [FLOOR_W-1:0]       cur_r, cur_nxt;
  logic [FLOOR_W-1:0]       goal_r, goal_nxt;
  logic [FLOORS-1:0]        req_r, req_nxt;
  phase_t                   phase_r, phase_nxt;
  logic signed [DIR_W-1:0]  head_r, head_nxt;

  // Search sequencer
  seq_t                     seq_r, seq_nxt;
  logic [CW-1:0]            scan_f_r, scan_f_nxt;
  logic [CW-1:0]            best_r, best_nxt;
  logic [CW-1:0]            best_d_r, best_d_nxt;

  // Result register
  logic                     out_valid_r, out_valid_nxt;
  logic [CMD_W-1:0]         out_cmd_r, out_cmd_nxt;
  logic signed [DIR_W-1:0]  out_dir_r, out_dir_nxt;
  logic [FLOOR_W-1:0]       out_floor_r, out_floor_nxt;
  logic [STATE_W-1:0]       out_state_r, out_state_nxt;

  logic                     in_rdy;
  logic                     in_acc;

  // Combinational helpers
  logic [FLOOR_W-1:0]       req_floor;
  logic [IDX_W-1:0]         req_idx;
  logic [FLOOR_W:0]         step_sum;
  logic [FLOOR_W-1:0]       step_floor;
  logic [IDX_W-1:0]         step_idx;
  logic [IDX_W-1:0]         scan_idx;
  logic [CW-1:0]            cur_ext;
  logic [CW-1:0]            scan_dist;
  logic                     emit;
  logic                     go_scan;
  cmd_t                     emit_cmd;
  logic signed [DIR_W-1:0]  emit_dir;

  assign in_rdy         = (seq_r == SQ_IDLE) && (!out_valid_r || out_chan.ready);
  assign in_acc         = in_chan.valid && in_rdy;
  assign in_chan.ready  = in_rdy;

  assign out_chan.valid      = out_valid_r;
  assign out_chan.command    = out_cmd_r;
  assign out_chan.move_dir   = out_dir_r;
  assign out_chan.floor_now  = out_floor_r;
  assign out_chan.ctrl_state = out_state_r;

  // Request decode
  assign req_floor = clamp_floor(in_chan.floor);
  assign req_idx   = IDX_W'(req_floor - FLOOR_W'(1));

  // One-floor step, clamped to the shaft
  assign step_sum   = {1'b0, cur_r} + {{(FLOOR_W-1){head_r[DIR_W-1]}}, head_r};
  assign step_floor = (step_sum == '0) ? FLOOR_W'(1) :
                      (step_sum > {1'b0, FLOOR_MAX}) ? FLOOR_MAX : step_sum[FLOOR_W-1:0];
  assign step_idx   = IDX_W'(step_floor - FLOOR_W'(1));

  // Shared distance unit used by the search
  assign scan_idx  = IDX_W'(scan_f_r - CW'(1));
  assign cur_ext   = CW'(cur_r);
  assign scan_dist = (scan_f_r > cur_ext) ? (scan_f_r - cur_ext) : (cur_ext - scan_f_r);

  always_comb begin
    start_nxt     = start_r;
    cur_nxt       = cur_r;
    goal_nxt      = goal_r;
    req_nxt       = req_r;
    phase_nxt     = phase_r;
    head_nxt      = head_r;
    seq_nxt       = seq_r;
    scan_f_nxt    = scan_f_r;
    best_nxt      = best_r;
    best_d_nxt    = best_d_r;
    out_valid_nxt = out_valid_r;
    out_cmd_nxt   = out_cmd_r;
    out_dir_nxt   = out_dir_r;
    out_floor_nxt = out_floor_r;
    out_state_nxt = out_state_r;
    emit          = 1'b0;
    go_scan       = 1'b0;
    emit_cmd      = CMD_NONE;
    emit_dir      = DIR_STAY;

    if (out_valid_r && out_chan.ready) begin
      out_valid_nxt = 1'b0;
    end

    // Start floor write; also repositions an idle cabin
    if (cfg_we) begin
      start_nxt = clamp_floor(cfg_wdata);
      if (phase_r == PH_FREE) begin
        cur_nxt = clamp_floor(cfg_wdata);
      end
    end

    case (seq_r)
      SQ_IDLE: begin
        if (in_acc) begin
          emit = 1'b1;
          case (in_chan.func)
            FN_REQUEST: begin
              if (!req_r[req_idx]) begin
                if (phase_r == PH_STOP && req_floor == cur_r) begin
                  // already standing here: just open the doors
                  emit_cmd = CMD_OPEN;
                end else begin
                  req_nxt[req_idx] = 1'b1;
                  if (phase_r == PH_FREE) begin
                    go_scan = 1'b1;
                  end
                end
              end
            end
            FN_MOVED: begin
              if (phase_r == PH_CHOOSE || phase_r == PH_MOVE) begin
                cur_nxt = step_floor;
                if (step_floor != goal_r && !req_r[step_idx]) begin
                  phase_nxt = PH_MOVE;
                  emit_cmd  = CMD_GO_ON;
                  emit_dir  = head_r;
                end else begin
                  phase_nxt         = PH_STOP;
                  req_nxt[step_idx] = 1'b0;
                  emit_cmd          = CMD_STOP;
                end
              end
            end
            FN_READY: begin
              if (phase_r == PH_FREE || phase_r == PH_STOP) begin
                go_scan = 1'b1;
              end
            end
            default: ;
          endcase
          if (go_scan) begin
            emit       = 1'b0;
            seq_nxt    = SQ_SCAN;
            scan_f_nxt = CW'(1);
            best_nxt   = '0;
            best_d_nxt = DIST_INIT;
          end
        end
      end
      SQ_SCAN: begin
        // strict less-than keeps the lower floor on a tie
        if (req_r[scan_idx] && scan_dist < best_d_r) begin
          best_nxt   = scan_f_r;
          best_d_nxt = scan_dist;
        end
        if (scan_f_r == SCAN_LAST) begin
          seq_nxt = SQ_FIN;
        end else begin
          scan_f_nxt = scan_f_r + CW'(1);
        end
      end
      SQ_FIN: begin
        emit    = 1'b1;
        seq_nxt = SQ_IDLE;
        if (best_r == '0) begin
          phase_nxt = PH_FREE;
        end else begin
          phase_nxt = PH_CHOOSE;
          goal_nxt  = FLOOR_W'(best_r);
          if (best_r == cur_ext) head_nxt = DIR_STAY;
          else if (best_r < cur_ext) head_nxt = DIR_DOWN;
          else head_nxt = DIR_UP;
          emit_cmd = CMD_PREPARE;
          emit_dir = head_nxt;
        end
      end
      default: begin
        seq_nxt = SQ_IDLE;
      end
    endcase

    if (emit) begin
      out_valid_nxt = 1'b1;
      out_cmd_nxt   = emit_cmd;
      out_dir_nxt   = emit_dir;
      out_floor_nxt = cur_nxt;
      out_state_nxt = phase_code(phase_nxt);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_r     <= FLOOR_W'(1);
      cur_r       <= FLOOR_W'(1);
      goal_r      <= '0;
      req_r       <= '0;
      phase_r     <= PH_FREE;
      head_r      <= DIR_STAY;
      seq_r       <= SQ_IDLE;
      scan_f_r    <= '0;
      best_r      <= '0;
      best_d_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      start_r     <= start_nxt;
      cur_r       <= cur_nxt;
      goal_r      <= goal_nxt;
      req_r       <= req_nxt;
      phase_r     <= phase_nxt;
      head_r      <= head_nxt;
      seq_r       <= seq_nxt;
      scan_f_r    <= scan_f_nxt;
      best_r      <= best_nxt;
      best_d_r    <= best_d_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Result payload: no reset needed
  always_ff @(posedge clk) begin
    out_cmd_r   <= out_cmd_nxt;
    out_dir_r   <= out_dir_nxt;
    out_floor_r <= out_floor_nxt;
    out_state_r <= out_state_nxt;
  end

  // The cabin never leaves the shaft
  a_floor_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (cur_r != '0) && (cur_r <= FLOOR_MAX))
    else $error("current floor out of range");

  // A finished search always lands in the result register
  a_fin_emits: assert property (@(posedge clk) disable iff (!rst_n)
    (seq_r == SQ_FIN) |=> out_valid_r)
    else $error("search finished without a result");

  // Search counter stays on real floors
  a_scan_bounds: assert property (@(posedge clk) disable iff (!rst_n)
    (seq_r == SQ_SCAN) |-> (scan_f_r != '0) && (scan_f_r <= SCAN_LAST))
    else $error("search counter out of range");

  // Stopped at a floor: that floor has no pending request
  a_stop_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_STOP) |-> !req_r[IDX_W'(cur_r - FLOOR_W'(1))])
    else $error("request left pending at the stopped floor");

  // A travelling cabin always has a target
  a_goal_set: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_CHOOSE || phase_r == PH_MOVE) |-> (goal_r != '0))
    else $error("moving without a target");

  // No new transaction while a search is running
  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (seq_r == SQ_SCAN || seq_r == SQ_FIN) |-> !in_acc)
    else $error("transaction accepted during search");

endmodule
